// ----- hdl/pscc_pkg.sv -----
// pscc_pkg: widths, register indexes, axis codes and shared types of the
// point sphere / cylinder clip unit
// no dependencies
package pscc_pkg;

  localparam int unsigned COORD_BITS    = 24;
  localparam int unsigned RAD_BITS      = COORD_BITS - 1;
  localparam int unsigned DIFF_BITS     = COORD_BITS + 1;
  localparam int unsigned MAG_BITS      = COORD_BITS + 1;
  localparam int unsigned SQ_BITS       = 2 * COORD_BITS + 1;
  localparam int unsigned SUM3_BITS     = SQ_BITS + 2;
  localparam int unsigned SUM2_BITS     = SQ_BITS + 1;
  localparam int unsigned RSQ_BITS      = 2 * RAD_BITS;
  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SPHERE_CX = 4'd0,
    REG_SPHERE_CY = 4'd1,
    REG_SPHERE_CZ = 4'd2,
    REG_SPHERE_R  = 4'd3,
    REG_CYL_AXIS  = 4'd4,
    REG_CYL_CU    = 4'd5,
    REG_CYL_CV    = 4'd6,
    REG_CYL_R     = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_X   = 2'd0,
    AXIS_Y   = 2'd1,
    AXIS_Z   = 2'd2,
    AXIS_OFF = 2'd3
  } axis_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sphere_cx;
    logic signed [COORD_BITS-1:0] sphere_cy;
    logic signed [COORD_BITS-1:0] sphere_cz;
    logic        [RAD_BITS-1:0]   sphere_r;
    axis_e                        cyl_axis;
    logic signed [COORD_BITS-1:0] cyl_cu;
    logic signed [COORD_BITS-1:0] cyl_cv;
    logic        [RAD_BITS-1:0]   cyl_r;
  } cfg_t;

  typedef struct packed {
    logic clipped;
    logic in_sphere;
    logic in_cylinder;
  } res_t;

  function automatic logic [MAG_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_BITS-1:0] d;
    d = DIFF_BITS'(a) - DIFF_BITS'(b);
    abs_diff = d[DIFF_BITS-1] ? MAG_BITS'(-d) : MAG_BITS'(d);
  endfunction

endpackage

// ----- hdl/pscc_datapath.sv -----
// pscc_datapath: four-stage distance pipeline (difference, square, sum, compare)
// depends on pscc_pkg
module pscc_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_vld_i,
  input  logic signed [pscc_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [pscc_pkg::COORD_BITS-1:0] point_y_i,
  input  logic signed [pscc_pkg::COORD_BITS-1:0] point_z_i,
  input  pscc_pkg::cfg_t                        cfg_i,
  output logic                                  out_vld_o,
  output pscc_pkg::res_t                        res_o
);

  // stage 1: absolute differences
  logic s1_vld_q;
  logic s1_cen_q;
  logic [pscc_pkg::MAG_BITS-1:0] s1_sx_q, s1_sy_q, s1_sz_q, s1_cu_q, s1_cv_q;
  logic signed [pscc_pkg::COORD_BITS-1:0] cyl_a, cyl_b;

  // stage 2: squares
  logic s2_vld_q;
  logic s2_cen_q;
  logic [pscc_pkg::SQ_BITS-1:0] s2_sx_q, s2_sy_q, s2_sz_q, s2_cu_q, s2_cv_q;
  logic [pscc_pkg::RSQ_BITS-1:0] s2_rs_q, s2_rc_q;

  // stage 3: sums
  logic s3_vld_q;
  logic s3_cen_q;
  logic [pscc_pkg::SUM3_BITS-1:0] s3_ds_q;
  logic [pscc_pkg::SUM2_BITS-1:0] s3_dc_q;
  logic [pscc_pkg::RSQ_BITS-1:0]  s3_rs_q, s3_rc_q;

  // stage 4: compare
  logic out_vld_q;
  pscc_pkg::res_t res_q;
  logic ins, inc;

  always_comb begin
    cyl_a = (cfg_i.cyl_axis == pscc_pkg::AXIS_X) ? point_y_i : point_x_i;
    cyl_b = (cfg_i.cyl_axis == pscc_pkg::AXIS_Z) ? point_y_i : point_z_i;
  end

  always_comb begin
    ins = pscc_pkg::SUM3_BITS'(s3_rs_q) > s3_ds_q;
    inc = s3_cen_q && (pscc_pkg::SUM2_BITS'(s3_rc_q) > s3_dc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= in_vld_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sx_q  <= pscc_pkg::abs_diff(point_x_i, cfg_i.sphere_cx);
    s1_sy_q  <= pscc_pkg::abs_diff(point_y_i, cfg_i.sphere_cy);
    s1_sz_q  <= pscc_pkg::abs_diff(point_z_i, cfg_i.sphere_cz);
    s1_cu_q  <= pscc_pkg::abs_diff(cyl_a, cfg_i.cyl_cu);
    s1_cv_q  <= pscc_pkg::abs_diff(cyl_b, cfg_i.cyl_cv);
    s1_cen_q <= cfg_i.cyl_axis != pscc_pkg::AXIS_OFF;

    s2_sx_q  <= pscc_pkg::SQ_BITS'(s1_sx_q * s1_sx_q);
    s2_sy_q  <= pscc_pkg::SQ_BITS'(s1_sy_q * s1_sy_q);
    s2_sz_q  <= pscc_pkg::SQ_BITS'(s1_sz_q * s1_sz_q);
    s2_cu_q  <= pscc_pkg::SQ_BITS'(s1_cu_q * s1_cu_q);
    s2_cv_q  <= pscc_pkg::SQ_BITS'(s1_cv_q * s1_cv_q);
    s2_rs_q  <= pscc_pkg::RSQ_BITS'(cfg_i.sphere_r * cfg_i.sphere_r);
    s2_rc_q  <= pscc_pkg::RSQ_BITS'(cfg_i.cyl_r * cfg_i.cyl_r);
    s2_cen_q <= s1_cen_q;

    s3_ds_q  <= pscc_pkg::SUM3_BITS'(s2_sx_q) + pscc_pkg::SUM3_BITS'(s2_sy_q)
              + pscc_pkg::SUM3_BITS'(s2_sz_q);
    s3_dc_q  <= pscc_pkg::SUM2_BITS'(s2_cu_q) + pscc_pkg::SUM2_BITS'(s2_cv_q);
    s3_rs_q  <= s2_rs_q;
    s3_rc_q  <= s2_rc_q;
    s3_cen_q <= s2_cen_q;

    res_q.clipped     <= !(ins || inc);
    res_q.in_sphere   <= ins;
    res_q.in_cylinder <= inc;
  end

  assign out_vld_o = out_vld_q;
  assign res_o     = res_q;

endmodule

// ----- hdl/point_sphere_cylinder_clip_unit.sv -----
// point_sphere_cylinder_clip_unit: top level, configuration registers and
// the distance pipeline; depends on pscc_pkg and pscc_datapath
//
// One point is taken in every cycle: busy stays low and start may be held
// high continuously. Each point gives one result, shown for one cycle with
// done high, once it has passed the four register stages of the pipeline
// (difference, square, sum, compare).
// Configuration writes are always ready and take effect at once; write them
// only while no point is in flight.
module point_sphere_cylinder_clip_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [pscc_pkg::COORD_BITS-1:0]   point_x_i,
  input  logic signed [pscc_pkg::COORD_BITS-1:0]   point_y_i,
  input  logic signed [pscc_pkg::COORD_BITS-1:0]   point_z_i,
  output logic                                     done_o,
  output logic                                     clipped_o,
  output logic                                     in_sphere_o,
  output logic                                     in_cylinder_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [pscc_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [pscc_pkg::CFG_DATA_BITS-1:0]       cfg_data_i
);

  pscc_pkg::cfg_t cfg_q, cfg_d;
  pscc_pkg::res_t res;
  logic           cfg_we;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (pscc_pkg::cfg_reg_e'(cfg_index_i))
        pscc_pkg::REG_SPHERE_CX: cfg_d.sphere_cx = cfg_data_i[pscc_pkg::COORD_BITS-1:0];
        pscc_pkg::REG_SPHERE_CY: cfg_d.sphere_cy = cfg_data_i[pscc_pkg::COORD_BITS-1:0];
        pscc_pkg::REG_SPHERE_CZ: cfg_d.sphere_cz = cfg_data_i[pscc_pkg::COORD_BITS-1:0];
        pscc_pkg::REG_SPHERE_R:  cfg_d.sphere_r  = cfg_data_i[pscc_pkg::RAD_BITS-1:0];
        pscc_pkg::REG_CYL_AXIS:  cfg_d.cyl_axis  = pscc_pkg::axis_e'(cfg_data_i[1:0]);
        pscc_pkg::REG_CYL_CU:    cfg_d.cyl_cu    = cfg_data_i[pscc_pkg::COORD_BITS-1:0];
        pscc_pkg::REG_CYL_CV:    cfg_d.cyl_cv    = cfg_data_i[pscc_pkg::COORD_BITS-1:0];
        pscc_pkg::REG_CYL_R:     cfg_d.cyl_r     = cfg_data_i[pscc_pkg::RAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sphere_cx <= '0;
      cfg_q.sphere_cy <= '0;
      cfg_q.sphere_cz <= '0;
      cfg_q.sphere_r  <= '0;
      cfg_q.cyl_axis  <= pscc_pkg::AXIS_Z;
      cfg_q.cyl_cu    <= '0;
      cfg_q.cyl_cv    <= '0;
      cfg_q.cyl_r     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pscc_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (start && !busy),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .cfg_i     (cfg_q),
    .out_vld_o (done_o),
    .res_o     (res)
  );

  assign clipped_o     = res.clipped;
  assign in_sphere_o   = res.in_sphere;
  assign in_cylinder_o = res.in_cylinder;

endmodule

// ----- hdl/pscc_checker.sv -----
// pscc_checker: port-level checks on request latency and result coding
// bound to point_sphere_cylinder_clip_unit; depends on nothing else
module pscc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic clipped_o,
  input logic in_sphere_o,
  input logic in_cylinder_o
);

  // every request gives a result with done high
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("request without result");

  // no result without an earlier request
  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start, 4) && !$past(busy, 4)))
    else $error("result without request");

  // clipped exactly when inside neither shape
  a_clip_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (clipped_o == !(in_sphere_o || in_cylinder_o)))
    else $error("clipped flag inconsistent");

endmodule

bind point_sphere_cylinder_clip_unit pscc_checker u_pscc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .clipped_o     (clipped_o),
  .in_sphere_o   (in_sphere_o),
  .in_cylinder_o (in_cylinder_o)
);

// ----- bench/tb_point_sphere_cylinder_clip_unit.sv -----
`timescale 1ns / 1ps
// tb_point_sphere_cylinder_clip_unit: self-checking bench for the point sphere / cylinder
// clip unit, bursty point stream against an exact squared-distance predictor
// depends on pscc_pkg and point_sphere_cylinder_clip_unit
module tb_point_sphere_cylinder_clip_unit;

  localparam int          STAGES      = 4;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 75;
  localparam logic [pscc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [pscc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 4'd15;
  localparam int          C_MAX = (1 << (pscc_pkg::COORD_BITS - 1)) - 1;
  localparam int          C_MIN = -(1 << (pscc_pkg::COORD_BITS - 1));
  localparam logic [pscc_pkg::RAD_BITS-1:0] R_MAX = {pscc_pkg::RAD_BITS{1'b1}};

  typedef struct packed {
    logic signed [pscc_pkg::COORD_BITS-1:0] x;
    logic signed [pscc_pkg::COORD_BITS-1:0] y;
    logic signed [pscc_pkg::COORD_BITS-1:0] z;
  } point_t;

  logic                                    clk_i = 1'b0;
  logic                                    rst_ni = 1'b0;
  logic                                    start = 1'b0;
  logic                                    busy;
  logic signed [pscc_pkg::COORD_BITS-1:0]  point_x = '0;
  logic signed [pscc_pkg::COORD_BITS-1:0]  point_y = '0;
  logic signed [pscc_pkg::COORD_BITS-1:0]  point_z = '0;
  logic                                    done;
  logic                                    clipped;
  logic                                    in_sphere;
  logic                                    in_cylinder;
  logic                                    cfg_valid = 1'b0;
  logic                                    cfg_ready;
  logic [pscc_pkg::CFG_IDX_BITS-1:0]       cfg_index = '0;
  logic [pscc_pkg::CFG_DATA_BITS-1:0]      cfg_data = '0;

  pscc_pkg::cfg_t shapes;
  point_t         point_q[$];
  pscc_pkg::res_t verdict_q[$];
  int             errors = 0;
  int             cycles = 0;
  int             gap_cnt = 0;
  int             burst_cnt = 1;
  bit             drain_wait = 1'b0;
  bit             drained_once = 1'b0;

  point_sphere_cylinder_clip_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .point_z_i     (point_z),
    .done_o        (done),
    .clipped_o     (clipped),
    .in_sphere_o   (in_sphere),
    .in_cylinder_o (in_cylinder),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] sq_gap(input logic signed [pscc_pkg::COORD_BITS-1:0] a,
                                         input logic signed [pscc_pkg::COORD_BITS-1:0] b);
    logic signed [pscc_pkg::COORD_BITS:0] d;
    logic [pscc_pkg::COORD_BITS:0]        m;
    d = {a[pscc_pkg::COORD_BITS-1], a} - {b[pscc_pkg::COORD_BITS-1], b};
    m = d[pscc_pkg::COORD_BITS] ? -d : d;
    return 64'(m) * 64'(m);
  endfunction

  function automatic pscc_pkg::res_t clip_verdict(input point_t p);
    logic [63:0]                            gap_sq;
    logic signed [pscc_pkg::COORD_BITS-1:0] u;
    logic signed [pscc_pkg::COORD_BITS-1:0] v;
    pscc_pkg::res_t                         r;
    gap_sq = sq_gap(p.x, shapes.sphere_cx) + sq_gap(p.y, shapes.sphere_cy)
           + sq_gap(p.z, shapes.sphere_cz);
    r.in_sphere   = gap_sq < 64'(shapes.sphere_r) * 64'(shapes.sphere_r);
    r.in_cylinder = 1'b0;
    if (shapes.cyl_axis != pscc_pkg::AXIS_OFF) begin
      u = (shapes.cyl_axis == pscc_pkg::AXIS_X) ? p.y : p.x;
      v = (shapes.cyl_axis == pscc_pkg::AXIS_Z) ? p.y : p.z;
      gap_sq = sq_gap(u, shapes.cyl_cu) + sq_gap(v, shapes.cyl_cv);
      r.in_cylinder = gap_sq < 64'(shapes.cyl_r) * 64'(shapes.cyl_r);
    end
    r.clipped = !(r.in_sphere || r.in_cylinder);
    return r;
  endfunction

  function automatic logic [pscc_pkg::COORD_BITS-1:0] near(
    input logic signed [pscc_pkg::COORD_BITS-1:0] c,
    input int r);
    int span;
    span = r + r / 2 + 2;
    return pscc_pkg::COORD_BITS'(int'(c) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic cfg_write(input logic [pscc_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [pscc_pkg::CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pscc_pkg::REG_SPHERE_CX: shapes.sphere_cx = data[pscc_pkg::COORD_BITS-1:0];
      pscc_pkg::REG_SPHERE_CY: shapes.sphere_cy = data[pscc_pkg::COORD_BITS-1:0];
      pscc_pkg::REG_SPHERE_CZ: shapes.sphere_cz = data[pscc_pkg::COORD_BITS-1:0];
      pscc_pkg::REG_SPHERE_R:  shapes.sphere_r  = data[pscc_pkg::RAD_BITS-1:0];
      pscc_pkg::REG_CYL_AXIS:  shapes.cyl_axis  = pscc_pkg::axis_e'(data[1:0]);
      pscc_pkg::REG_CYL_CU:    shapes.cyl_cu    = data[pscc_pkg::COORD_BITS-1:0];
      pscc_pkg::REG_CYL_CV:    shapes.cyl_cv    = data[pscc_pkg::COORD_BITS-1:0];
      pscc_pkg::REG_CYL_R:     shapes.cyl_r     = data[pscc_pkg::RAD_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_shapes(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [31:0] sr,
                            input logic [31:0] axis, input logic [31:0] cu,
                            input logic [31:0] cv, input logic [31:0] cr);
    cfg_write(pscc_pkg::REG_SPHERE_CX, cx);
    cfg_write(pscc_pkg::REG_SPHERE_CY, cy);
    cfg_write(pscc_pkg::REG_SPHERE_CZ, cz);
    cfg_write(pscc_pkg::REG_SPHERE_R, sr);
    cfg_write(pscc_pkg::REG_CYL_AXIS, axis);
    cfg_write(pscc_pkg::REG_CYL_CU, cu);
    cfg_write(pscc_pkg::REG_CYL_CV, cv);
    cfg_write(pscc_pkg::REG_CYL_R, cr);
  endtask

  task automatic add_point(input int x, input int y, input int z);
    point_t pt;
    pt.x = pscc_pkg::COORD_BITS'(x);
    pt.y = pscc_pkg::COORD_BITS'(y);
    pt.z = pscc_pkg::COORD_BITS'(z);
    point_q = {point_q, pt};
  endtask

  task automatic settle();
    do @(negedge clk_i); while (point_q.size() != 0 || start || verdict_q.size() != 0);
  endtask

  // request driver: bursts with random gaps, sometimes draining the pipeline
  always @(posedge clk_i) begin : driver
    point_t nxt;
    logic   go;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start)
        verdict_q = {verdict_q, clip_verdict('{x: point_x, y: point_y, z: point_z})};
      go = 1'b0;
      if (drain_wait) drain_wait = (verdict_q.size() != 0);
      if (!drain_wait) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (point_q.size() > 0) begin
          nxt = point_q.pop_front();
          point_x <= nxt.x;
          point_y <= nxt.y;
          point_z <= nxt.z;
          go = 1'b1;
          if (burst_cnt > 0) burst_cnt--;
          if (burst_cnt == 0) begin
            burst_cnt = $urandom_range(1, 40);
            gap_cnt   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (!drained_once || $urandom_range(0, 15) == 0) begin
              drain_wait   = 1'b1;
              drained_once = 1'b1;
            end
          end
        end
      end
      start <= go;
    end
  end

  always @(posedge clk_i) begin : monitor
    pscc_pkg::res_t want;
    if (rst_ni && done) begin
      if (verdict_q.size() == 0) begin
        $error("result with no request outstanding: clipped %0b in_sphere %0b in_cylinder %0b",
               clipped, in_sphere, in_cylinder);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, clipped);
          errors++;
        end
        if (in_sphere !== want.in_sphere) begin
          $error("in_sphere: expected %0b, got %0b", want.in_sphere, in_sphere);
          errors++;
        end
        if (in_cylinder !== want.in_cylinder) begin
          $error("in_cylinder: expected %0b, got %0b", want.in_cylinder, in_cylinder);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_point_sphere_cylinder_clip_unit NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    point_t pt;
    int     k;
    int     sr;
    int     cr;
    int     sel;
    int     axis;
    logic [pscc_pkg::COORD_BITS-1:0] c [5];
    shapes = '{sphere_cx: '0, sphere_cy: '0, sphere_cz: '0, sphere_r: '0,
               cyl_axis: pscc_pkg::AXIS_Z, cyl_cu: '0, cyl_cv: '0, cyl_r: '0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero radii after reset: everything is clipped
    add_point(0, 0, 0);
    add_point(C_MAX, C_MAX, C_MAX);
    add_point(C_MIN, C_MIN, C_MIN);
    settle();

    // sphere of radius 256 and x-axis cylinder of radius 128, boundaries, spare indexes ignored
    set_shapes(0, 0, 0, 256, 32'(pscc_pkg::AXIS_X), 0, 0, 128);
    cfg_write(REG_SPARE_LO, '1);
    cfg_write(REG_SPARE_HI, 32'h5a5a_5a5a);
    add_point(256, 0, 0);
    add_point(255, 0, 0);
    add_point(0, 128, 0);
    add_point(1000, 127, 0);
    add_point(1000, 0, -128);
    add_point(0, 0, -255);
    settle();

    // extreme centres and radii, y-axis cylinder
    set_shapes(32'(C_MIN), 32'(C_MIN), 32'(C_MIN), 32'hff80_0000 | R_MAX,
               32'(pscc_pkg::AXIS_Y), 32'(C_MAX), 32'(C_MAX), 32'(R_MAX));
    add_point(C_MAX, C_MAX, C_MAX);
    add_point(C_MIN, C_MIN, C_MIN);
    add_point(-1, C_MIN, C_MIN);
    add_point(-2, C_MIN, C_MIN);
    add_point(C_MAX, 0, C_MIN);
    settle();

    // z-axis cylinder of unit radius with excess data bits, then disabled
    set_shapes(32'hdead_0100, 5, -7, 0, 32'habcd_0002, -512, 300, 32'hff00_0001);
    add_point(-512, 300, C_MAX);
    add_point(-511, 300, 0);
    settle();
    cfg_write(pscc_pkg::REG_CYL_AXIS, 32'(pscc_pkg::AXIS_OFF));
    cfg_write(pscc_pkg::REG_CYL_R, 32'(R_MAX));
    add_point(-512, 300, 0);
    add_point(0, 0, 0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      k = $urandom_range(0, 22);
      for (int i = 0; i < 5; i++)
        c[i] = $urandom_range(0, 1) ? pscc_pkg::COORD_BITS'($urandom)
             : pscc_pkg::COORD_BITS'(int'($urandom_range(0, 2 << k)) - (1 << k));
      sr = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1 << k);
      cr = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1 << $urandom_range(0, 22));
      if (p == PHASES - 1) begin
        sr = int'(R_MAX);
        cr = int'(R_MAX);
      end
      axis = (p < 4) ? p : $urandom_range(0, 3);
      set_shapes({8'($urandom), c[0]}, {8'($urandom), c[1]}, {8'($urandom), c[2]},
                 {9'($urandom), pscc_pkg::RAD_BITS'(sr)}, {30'($urandom), 2'(axis)},
                 {8'($urandom), c[3]}, {8'($urandom), c[4]},
                 {9'($urandom), pscc_pkg::RAD_BITS'(cr)});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pt.x = pscc_pkg::COORD_BITS'($urandom);
        pt.y = pscc_pkg::COORD_BITS'($urandom);
        pt.z = pscc_pkg::COORD_BITS'($urandom);
        sel = $urandom_range(0, 9);
        if (sel <= 3) begin
          pt.x = near(shapes.sphere_cx, sr);
          pt.y = near(shapes.sphere_cy, sr);
          pt.z = near(shapes.sphere_cz, sr);
        end else if (sel <= 6) begin
          case (shapes.cyl_axis)
            pscc_pkg::AXIS_X: begin
              pt.y = near(shapes.cyl_cu, cr);
              pt.z = near(shapes.cyl_cv, cr);
            end
            pscc_pkg::AXIS_Y: begin
              pt.x = near(shapes.cyl_cu, cr);
              pt.z = near(shapes.cyl_cv, cr);
            end
            default: begin
              pt.x = near(shapes.cyl_cu, cr);
              pt.y = near(shapes.cyl_cv, cr);
            end
          endcase
        end else if (sel == 7) begin
          pt.x = pscc_pkg::COORD_BITS'(int'(shapes.sphere_cx) + sr
                                       + int'($urandom_range(0, 2)) - 1);
          pt.y = shapes.sphere_cy;
          pt.z = shapes.sphere_cz;
        end
        point_q = {point_q, pt};
      end
      settle();
    end

    repeat (STAGES + 4) @(posedge clk_i);
    if (errors == 0)
      $display("tb_point_sphere_cylinder_clip_unit OK");
    else
      $display("tb_point_sphere_cylinder_clip_unit NOT OK");
    $finish;
  end

endmodule
